>>> hdl/six_button_pad_reader_defines.svh
// Assertion macros shared by the pad reader RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef SIX_BUTTON_PAD_READER_DEFINES_SVH
`define SIX_BUTTON_PAD_READER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SBPR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SBPR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/sbpr_pkg.sv
// Package for the six-button pad reader: phase codes, line and port bit
// positions, the held-button record and the keypad code table. No dependencies.
`default_nettype none

package sbpr_pkg;

  // Frame phases that do work
  localparam logic [2:0] PHASE_CLEAR = 3'd0;
  localparam logic [2:0] PHASE_THREE = 3'd2;
  localparam logic [2:0] PHASE_DIRS  = 3'd3;
  localparam logic [2:0] PHASE_SIX   = 3'd4;
  localparam logic [2:0] PHASE_EXTRA = 3'd5;
  localparam logic [2:0] PHASE_LAST  = 3'd7;

  // Active-low pad line positions
  localparam int unsigned LINE_UP    = 0;
  localparam int unsigned LINE_DOWN  = 1;
  localparam int unsigned LINE_LEFT  = 2;
  localparam int unsigned LINE_RIGHT = 3;
  localparam int unsigned LINE_FIRE  = 4;
  localparam int unsigned LINE_ALT   = 5;

  // Console port
  localparam logic [6:0] PORT_MASK  = 7'h4F;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_POUND = 8'h23;
  localparam logic [3:0] CHAR_DIGIT_HI = 4'h3;
  localparam logic [3:0] DIGIT_MAX  = 4'd9;

  // Key codes, bit0 up, bit1 right, bit2 down, bit3 left
  localparam logic [3:0] CODE_STAR  = 4'b0110;
  localparam logic [3:0] CODE_POUND = 4'b1001;
  localparam logic [3:0] CODE_ONE   = 4'b0010;

  // Register indexes
  localparam logic REG_KEYPAD_MODE = 1'b0;

  typedef struct packed {
    logic [3:0] dirs;
    logic [3:0] face;
    logic [3:0] extra;
    logic [1:0] kind;
  } held_t;

  typedef struct packed {
    logic  select_next;
    logic  frame_done;
    held_t held;
  } frame_res_t;

  function automatic logic [3:0] keypad_code(input logic [3:0] digit);
    logic [3:0] code;
    unique case (digit)
      4'd0:    code = 4'b0101;
      4'd1:    code = CODE_ONE;
      4'd2:    code = 4'b1000;
      4'd3:    code = 4'b0011;
      4'd4:    code = 4'b1101;
      4'd5:    code = 4'b1100;
      4'd6:    code = 4'b0001;
      4'd7:    code = 4'b1010;
      4'd8:    code = 4'b1110;
      4'd9:    code = 4'b0100;
      default: code = 4'b0000;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

>>> hdl/sbpr_in_if.sv
// Input channel of the pad reader: one line sample per transfer.
// Depends on nothing.
`default_nettype none

interface sbpr_in_if;
  logic       valid;
  logic       ready;
  logic [5:0] raw_lines;
  logic       key_valid;
  logic [7:0] key_char;

  modport source (output valid, raw_lines, key_valid, key_char, input ready);
  modport sink   (input valid, raw_lines, key_valid, key_char, output ready);
endinterface

`default_nettype wire

>>> hdl/sbpr_out_if.sv
// Result channel of the pad reader: one result per accepted sample.
// Depends on nothing.
`default_nettype none

interface sbpr_out_if;
  logic       valid;
  logic       ready;
  logic       select_next;
  logic       frame_done;
  logic [3:0] direction_bits;
  logic [3:0] face_bits;
  logic [3:0] extra_bits;
  logic [1:0] pad_kind;
  logic [6:0] console_port;

  modport source (output valid, select_next, frame_done, direction_bits, face_bits,
                  extra_bits, pad_kind, console_port, input ready);
  modport sink   (input valid, select_next, frame_done, direction_bits, face_bits,
                  extra_bits, pad_kind, console_port, output ready);
endinterface

`default_nettype wire

>>> hdl/sbpr_frame.sv
// Phase counter and held-button registers of the pad reader.
// Depends on sbpr_pkg.
`default_nettype none

module sbpr_frame (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                advance_i,
  input  wire logic [5:0]          raw_lines_i,
  output sbpr_pkg::frame_res_t     res_o
);

  logic [2:0]      phase_q, phase_d;
  sbpr_pkg::held_t held_q, held_d;
  logic            done;

  always_comb begin
    held_d = held_q;
    done   = 1'b0;
    unique case (phase_q)
      sbpr_pkg::PHASE_CLEAR: begin
        held_d = '0;
      end
      sbpr_pkg::PHASE_THREE: begin
        if (!raw_lines_i[sbpr_pkg::LINE_LEFT] && !raw_lines_i[sbpr_pkg::LINE_RIGHT]) begin
          held_d.kind[0] = 1'b1;
          held_d.face[0] = ~raw_lines_i[sbpr_pkg::LINE_FIRE];
          held_d.face[3] = ~raw_lines_i[sbpr_pkg::LINE_ALT];
        end
      end
      sbpr_pkg::PHASE_DIRS: begin
        held_d.dirs    = ~raw_lines_i[3:0];
        held_d.face[1] = ~raw_lines_i[sbpr_pkg::LINE_FIRE];
        held_d.face[2] = ~raw_lines_i[sbpr_pkg::LINE_ALT];
      end
      sbpr_pkg::PHASE_SIX: begin
        if (!raw_lines_i[sbpr_pkg::LINE_UP] && !raw_lines_i[sbpr_pkg::LINE_DOWN]) begin
          held_d.kind[1] = 1'b1;
        end
      end
      sbpr_pkg::PHASE_EXTRA: begin
        if (held_q.kind[1]) begin
          held_d.extra = {~raw_lines_i[sbpr_pkg::LINE_RIGHT], ~raw_lines_i[sbpr_pkg::LINE_UP],
                          ~raw_lines_i[sbpr_pkg::LINE_DOWN], ~raw_lines_i[sbpr_pkg::LINE_LEFT]};
        end
      end
      sbpr_pkg::PHASE_LAST: begin
        done = 1'b1;
      end
      default: begin
        held_d = held_q;
      end
    endcase
  end

  assign phase_d = phase_q + 3'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      held_q  <= '0;
    end else if (advance_i) begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

  assign res_o.select_next = phase_d[0];
  assign res_o.frame_done  = done;
  assign res_o.held        = held_d;

endmodule

`default_nettype wire

>>> hdl/sbpr_port.sv
// Console port translation (joystick or keypad) for the pad reader.
// Depends on sbpr_pkg.
`default_nettype none

module sbpr_port (
  input  wire logic            keypad_mode_i,
  input  wire sbpr_pkg::held_t held_i,
  input  wire logic            key_valid_i,
  input  wire logic [7:0]      key_char_i,
  output logic [6:0]           console_port_o
);

  logic [3:0] key_code;
  logic [6:0] code;
  logic       is_digit;

  assign is_digit = (key_char_i[7:4] == sbpr_pkg::CHAR_DIGIT_HI) &&
                    (key_char_i[3:0] <= sbpr_pkg::DIGIT_MAX);

  always_comb begin
    key_code = 4'b0000;
    if (key_valid_i) begin
      if (is_digit) begin
        key_code = sbpr_pkg::keypad_code(key_char_i[3:0]);
      end else if (key_char_i == sbpr_pkg::CHAR_STAR) begin
        key_code = sbpr_pkg::CODE_STAR;
      end else if (key_char_i == sbpr_pkg::CHAR_POUND) begin
        key_code = sbpr_pkg::CODE_POUND;
      end
    end else if (held_i.extra[0]) begin
      key_code = sbpr_pkg::CODE_ONE;
    end
  end

  always_comb begin
    if (keypad_mode_i) begin
      code = {held_i.face[0], 2'b00, key_code};
    end else begin
      // port order: up, right, down, left; fire from B
      code = {held_i.face[1], 2'b00, held_i.dirs[2], held_i.dirs[1],
              held_i.dirs[3], held_i.dirs[0]};
    end
  end

  assign console_port_o = ~code & sbpr_pkg::PORT_MASK;

endmodule

`default_nettype wire

>>> hdl/six_button_pad_reader.sv
// Top level of the six-button pad reader: sample register, frame logic,
// port translation, result register and APB configuration.
// Depends on sbpr_pkg, sbpr_in_if, sbpr_out_if, sbpr_frame, sbpr_port and the defines header.
//
// Usage:
//   in_i carries one active-low pad line sample per phase of an eight-phase
//   select frame, with the typed key state; out_o returns one result per
//   sample, giving the select level for the next phase and, on the last
//   phase, the button set, pad kind and console port value.
//   A transfer on in_i lands in the sample register, and the frame logic
//   runs from there into the result register. Throughput is one sample per
//   cycle while out_o does not stall; the frame update between the two
//   registers is combinational.
//   When out_o stalls, the result register holds and the sample register
//   takes one more transfer only if it is empty; then in_i.ready drops.
//   Reset clears the phase counter, all held buttons, keypad_mode and both
//   valid flags; the first sample after reset is phase 0.
//   keypad_mode sits at byte address 0 of the APB port; write it only idle.
`default_nettype none
`include "six_button_pad_reader_defines.svh"

module six_button_pad_reader (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  sbpr_in_if.sink           in_i,
  sbpr_out_if.source        out_o,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // Configuration register
  logic keypad_mode_q;
  logic cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready &&
                     (paddr[2] == sbpr_pkg::REG_KEYPAD_MODE);
  assign prdata    = (paddr[2] == sbpr_pkg::REG_KEYPAD_MODE) ? {31'd0, keypad_mode_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keypad_mode_q <= 1'b0;
    end else if (cfg_write) begin
      keypad_mode_q <= pwdata[0];
    end
  end

  // Sample register
  logic       s1_valid_q;
  logic [5:0] s1_raw_q;
  logic       s1_key_valid_q;
  logic [7:0] s1_key_char_q;
  logic       s1_adv;
  logic       out_free;

  // Result register
  logic       out_valid_q;
  logic       sel_q, sel_d;
  logic       done_q, done_d;
  logic [3:0] dirs_q, dirs_d;
  logic [3:0] face_q, face_d;
  logic [3:0] extra_q, extra_d;
  logic [1:0] kind_q, kind_d;
  logic [6:0] port_q, port_d;

  sbpr_pkg::frame_res_t frame_res;
  logic [6:0]           port_val;

  assign out_free   = !out_valid_q || out_o.ready;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_raw_q       <= in_i.raw_lines;
      s1_key_valid_q <= in_i.key_valid;
      s1_key_char_q  <= in_i.key_char;
    end
  end

  sbpr_frame u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (s1_adv),
    .raw_lines_i (s1_raw_q),
    .res_o       (frame_res)
  );

  sbpr_port u_port (
    .keypad_mode_i  (keypad_mode_q),
    .held_i         (frame_res.held),
    .key_valid_i    (s1_key_valid_q),
    .key_char_i     (s1_key_char_q),
    .console_port_o (port_val)
  );

  // Report the button set only on the last phase; idle value otherwise
  always_comb begin
    sel_d  = frame_res.select_next;
    done_d = frame_res.frame_done;
    if (frame_res.frame_done) begin
      dirs_d  = frame_res.held.dirs;
      face_d  = frame_res.held.face;
      extra_d = frame_res.held.extra;
      kind_d  = frame_res.held.kind;
      port_d  = port_val;
    end else begin
      dirs_d  = '0;
      face_d  = '0;
      extra_d = '0;
      kind_d  = '0;
      port_d  = sbpr_pkg::PORT_MASK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      sel_q   <= sel_d;
      done_q  <= done_d;
      dirs_q  <= dirs_d;
      face_q  <= face_d;
      extra_q <= extra_d;
      kind_q  <= kind_d;
      port_q  <= port_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.select_next    = sel_q;
  assign out_o.frame_done     = done_q;
  assign out_o.direction_bits = dirs_q;
  assign out_o.face_bits      = face_q;
  assign out_o.extra_bits     = extra_q;
  assign out_o.pad_kind       = kind_q;
  assign out_o.console_port   = port_q;

  `SBPR_ASSERT_NEXT(a_adv_fills_out, clk_i, rst_ni, s1_adv, out_valid_q, "result register not filled after advance")
  `SBPR_ASSERT_SAME(a_idle_port, clk_i, rst_ni, out_valid_q && !done_q, (port_q == sbpr_pkg::PORT_MASK) && (kind_q == 2'b00), "mid-frame result not idle")
  `SBPR_ASSERT_SAME(a_done_select_low, clk_i, rst_ni, out_valid_q && done_q, !sel_q, "frame end must restart with select low")

endmodule

`default_nettype wire
